@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated property checks used by the accumulator unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define GLSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to another one at the next edge.
`define GLSA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ src/glsa_pkg.sv @@
// ----------------------------------------------------------------------------
// glsa_pkg
// Sizes, field widths and codes of the genotype linking score accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glsa_pkg;

  localparam int MAX_INDIVIDUALS = 4096;
  localparam int FRACTION_BITS   = 16;
  localparam int GUARD_BITS      = 8;
  localparam int LOG_FRAC        = FRACTION_BITS + GUARD_BITS;

  // Field widths of the channels
  localparam int IND_W    = 12;
  localparam int GT_W     = 3;
  localparam int CALL_W   = 2;
  localparam int NUM_W    = 13;
  localparam int SCORE_W  = 40;

  // Internal widths
  localparam int IDX_W    = $clog2(MAX_INDIVIDUALS);
  localparam int CNT_W    = $clog2(MAX_INDIVIDUALS + 1);
  localparam int K_W      = $clog2(CNT_W);
  localparam int LOG_W    = K_W + LOG_FRAC;
  localparam int INC_W    = LOG_W - GUARD_BITS + 1;
  localparam int MANT_W   = 32;
  localparam int SH_W     = $clog2(MANT_W);
  localparam int STEP_W   = $clog2(LOG_FRAC + 1);

  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(4096);

  // Commands
  localparam logic CMD_ELEM = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Phased reference genotypes
  localparam logic [GT_W-1:0] GT_00 = 3'd0;
  localparam logic [GT_W-1:0] GT_01 = 3'd1;
  localparam logic [GT_W-1:0] GT_10 = 3'd2;
  localparam logic [GT_W-1:0] GT_11 = 3'd3;

  // Called genotypes
  localparam logic [CALL_W-1:0] CALL_HET = 2'd1;
  localparam logic [CALL_W-1:0] CALL_HOM = 2'd2;

endpackage

@@ src/glsa_if.sv @@
// ----------------------------------------------------------------------------
// glsa_if
// Valid/ready channels of the accumulator: items in, scores out, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface glsa_elem_if
  import glsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [IND_W-1:0]  individual;
  logic [GT_W-1:0]   genotype;
  logic [CALL_W-1:0] called_genotype;
  logic              last_in_row;

  modport source (output valid, command, individual, genotype, called_genotype,
                  last_in_row, input ready);
  modport sink   (input valid, command, individual, genotype, called_genotype,
                  last_in_row, output ready);
endinterface

interface glsa_score_if
  import glsa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [IND_W-1:0]   score_individual;
  logic [SCORE_W-1:0] score;

  modport source (output valid, score_individual, score, input ready);
  modport sink   (input valid, score_individual, score, output ready);
endinterface

interface glsa_cfg_if
  import glsa_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ src/genotype_linking_score_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// genotype_linking_score_accumulator_unit
// Marks individuals per variant row and adds log2(N) - log2(count) to their
// saturating scores at the end of the row; answers score reads.
// ----------------------------------------------------------------------------
// After reset the block clears its score and mark memories, one entry a cycle,
// over all MAX_INDIVIDUALS (4096) entries, and takes no item meanwhile;
// configuration writes are taken at any time. A genotype element reads its mark
// from the mark memory, which has a registered read, and writes it back in the
// state that follows. A score read goes through the score memory into the output
// register, which holds the result while further elements are taken. The
// element that ends a row adds the row update: no logarithm when no score
// changes, else two logarithms run through one 32x32 squaring multiplier at one
// fraction bit a cycle; then a sweep over the mark and score memories up to one
// more than the highest in-row individual that the row touched.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module genotype_linking_score_accumulator_unit
  import glsa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  glsa_cfg_if.sink     cfg_i,
  glsa_elem_if.sink    in_i,
  glsa_score_if.source out_o
);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_FLAG    = 7'b0000100,
    ST_READ    = 7'b0001000,
    ST_LOGINIT = 7'b0010000,
    ST_LOGSQ   = 7'b0100000,
    ST_SWEEP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [NUM_W-1:0]   num_q, num_d;
  logic [IDX_W-1:0]   clr_idx_q, clr_idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   hwm_q, hwm_d;
  logic [CNT_W-1:0]   sw_idx_q, sw_idx_d;
  logic               sw_v_q, sw_v_d;
  logic               pass_q, pass_d;
  logic               apply_q, apply_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers
  logic [IND_W-1:0]   ind_q, ind_d;
  logic [GT_W-1:0]    gt_q, gt_d;
  logic [CALL_W-1:0]  called_q, called_d;
  logic               last_q, last_d;
  logic               range_q, range_d;
  logic [CNT_W-1:0]   n_row_q, n_row_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [MANT_W-1:0]  m_q, m_d;
  logic [2*MANT_W-1:0] prod_q, prod_d;
  logic [LOG_FRAC-1:0] frac_q, frac_d;
  logic [LOG_W-1:0]   ln_q, ln_d;
  logic [INC_W-1:0]   inc_q, inc_d;
  logic [IDX_W-1:0]   sw_addr_q, sw_addr_d;
  logic               sw_inn_q, sw_inn_d;
  logic [IND_W-1:0]   out_ind_q, out_ind_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;

  // Memories
  logic               flag_mem [MAX_INDIVIDUALS];
  logic [SCORE_W-1:0] score_mem [MAX_INDIVIDUALS];
  logic               flag_we, flag_wd, flag_rd_q;
  logic [IDX_W-1:0]   flag_wa, rd_addr;
  logic               score_we;
  logic [IDX_W-1:0]   score_wa;
  logic [SCORE_W-1:0] score_wd, score_rd_q;

  // Datapath
  logic [CNT_W-1:0]   n_eff;
  logic               in_accept;
  logic               elem_match, flag_new;
  logic [CNT_W-1:0]   ind_next;
  logic [CNT_W-1:0]   x_sel;
  logic [K_W-1:0]     x_lead;
  logic [MANT_W-1:0]  m_init;
  logic [MANT_W:0]    sq_top;
  logic               sq_bit;
  logic [MANT_W-1:0]  m_next, m_cur;
  logic [LOG_W-1:0]   log_val, log_diff;
  logic [LOG_W:0]     inc_full;
  logic               sw_issue;
  logic [SCORE_W:0]   score_sum;
  logic [SCORE_W-1:0] score_sat;

  function automatic logic [K_W-1:0] lead_one(input logic [CNT_W-1:0] x);
    logic [K_W-1:0] k;
    k = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (x[b]) begin
        k = K_W'(b);
      end
    end
    return k;
  endfunction

  assign n_eff = (32'(num_q) < MAX_INDIVIDUALS) ? CNT_W'(num_q) : CNT_W'(MAX_INDIVIDUALS);

  // Elements never wait on the output register; reads wait while it is full and not taken
  assign in_i.ready  = (state_q == ST_IDLE) &&
                       ((in_i.command == CMD_ELEM) || !out_valid_q || out_o.ready);
  assign in_accept   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid            = out_valid_q;
  assign out_o.score_individual = out_ind_q;
  assign out_o.score            = out_score_q;

  // Mark update of the element held in the payload registers
  assign elem_match = ((called_q == CALL_HET) && ((gt_q == GT_01) || (gt_q == GT_10))) ||
                      ((called_q == CALL_HOM) && (gt_q == GT_11));
  assign flag_new   = elem_match ? 1'b1 : ((gt_q == GT_00) ? 1'b0 : flag_rd_q);
  assign ind_next   = CNT_W'(ind_q) + CNT_W'(1);

  // Logarithm: normalize, then one squaring per fraction bit
  assign x_sel    = pass_q ? count_q : n_row_q;
  assign x_lead   = lead_one(x_sel);
  assign m_init   = MANT_W'(x_sel) << (SH_W'(MANT_W - 1) - SH_W'(x_lead));
  assign sq_top   = prod_q[2*MANT_W-1:MANT_W-1];
  assign sq_bit   = sq_top[MANT_W];
  assign m_next   = sq_bit ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
  assign m_cur    = (step_q == '0) ? m_q : m_next;
  assign log_val  = {k_q, frac_q[LOG_FRAC-2:0], sq_bit};
  assign log_diff = (ln_q >= log_val) ? (ln_q - log_val) : '0;
  assign inc_full = (LOG_W+1)'(log_diff) + (LOG_W+1)'(1 << (GUARD_BITS - 1));

  // Sweep datapath
  assign sw_issue  = sw_idx_q < hwm_q;
  assign score_sum = (SCORE_W+1)'(score_rd_q) + (SCORE_W+1)'(inc_q);
  assign score_sat = score_sum[SCORE_W] ? {SCORE_W{1'b1}} : score_sum[SCORE_W-1:0];

  assign rd_addr = (state_q == ST_SWEEP) ? IDX_W'(sw_idx_q) : IDX_W'(in_i.individual);

  always_comb begin
    flag_we  = 1'b0;
    flag_wa  = sw_addr_q;
    flag_wd  = 1'b0;
    score_we = 1'b0;
    score_wa = sw_addr_q;
    score_wd = score_sat;
    case (state_q)
      ST_CLEAR: begin
        flag_we  = 1'b1;
        flag_wa  = clr_idx_q;
        flag_wd  = 1'b0;
        score_we = 1'b1;
        score_wa = clr_idx_q;
        score_wd = '0;
      end
      ST_FLAG: begin
        flag_we = range_q;
        flag_wa = IDX_W'(ind_q);
        flag_wd = flag_new;
      end
      ST_SWEEP: begin
        flag_we  = sw_v_q;
        score_we = sw_v_q && apply_q && flag_rd_q && sw_inn_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    flag_rd_q <= flag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (score_we) begin
      score_mem[score_wa] <= score_wd;
    end
    score_rd_q <= score_mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    clr_idx_d   = clr_idx_q;
    count_d     = count_q;
    hwm_d       = hwm_q;
    sw_idx_d    = sw_idx_q;
    sw_v_d      = sw_v_q;
    pass_d      = pass_q;
    apply_d     = apply_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    ind_d       = ind_q;
    gt_d        = gt_q;
    called_d    = called_q;
    last_d      = last_q;
    range_d     = range_q;
    n_row_d     = n_row_q;
    k_d         = k_q;
    m_d         = m_q;
    prod_d      = prod_q;
    frac_d      = frac_q;
    ln_d        = ln_q;
    inc_d       = inc_q;
    sw_addr_d   = sw_addr_q;
    sw_inn_d    = sw_inn_q;
    out_ind_d   = out_ind_q;
    out_score_d = out_score_q;

    if (cfg_i.valid) begin
      num_d = cfg_i.data;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(MAX_INDIVIDUALS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          ind_d    = in_i.individual;
          gt_d     = in_i.genotype;
          called_d = in_i.called_genotype;
          last_d   = in_i.last_in_row;
          n_row_d  = n_eff;
          if (in_i.command == CMD_READ) begin
            range_d = 32'(in_i.individual) < MAX_INDIVIDUALS;
            state_d = ST_READ;
          end else begin
            range_d = CNT_W'(in_i.individual) < n_eff;
            state_d = ST_FLAG;
          end
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_ind_d   = ind_q;
        out_score_d = range_q ? score_rd_q : '0;
        state_d     = ST_IDLE;
      end
      ST_FLAG: begin
        if (range_q) begin
          if (flag_new && !flag_rd_q) begin
            count_d = count_q + CNT_W'(1);
          end else if (!flag_new && flag_rd_q && (count_q != '0)) begin
            count_d = count_q - CNT_W'(1);
          end
          if (ind_next > hwm_q) begin
            hwm_d = ind_next;
          end
        end
        if (last_q) begin
          pass_d   = 1'b0;
          sw_idx_d = '0;
          sw_v_d   = 1'b0;
          state_d  = ST_LOGINIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOGINIT: begin
        if (!pass_q && ((count_q == '0) || (count_q > n_row_q))) begin
          apply_d = 1'b0;
          state_d = ST_SWEEP;
        end else begin
          m_d     = m_init;
          k_d     = x_lead;
          step_d  = '0;
          frac_d  = '0;
          state_d = ST_LOGSQ;
        end
      end
      ST_LOGSQ: begin
        step_d = step_q + STEP_W'(1);
        prod_d = (2*MANT_W)'(m_cur) * (2*MANT_W)'(m_cur);
        if (step_q != '0) begin
          frac_d = {frac_q[LOG_FRAC-2:0], sq_bit};
        end
        if (step_q == STEP_W'(LOG_FRAC)) begin
          if (!pass_q) begin
            ln_d    = log_val;
            pass_d  = 1'b1;
            state_d = ST_LOGINIT;
          end else begin
            inc_d   = inc_full[LOG_W:GUARD_BITS];
            apply_d = 1'b1;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        // Issue one entry a cycle; the previous one is written back meanwhile
        if (sw_issue) begin
          sw_idx_d  = sw_idx_q + CNT_W'(1);
          sw_v_d    = 1'b1;
          sw_addr_d = IDX_W'(sw_idx_q);
          sw_inn_d  = sw_idx_q < n_row_q;
        end else begin
          sw_v_d = 1'b0;
          if (!sw_v_q) begin
            count_d = '0;
            hwm_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      num_q       <= NUM_RESET;
      clr_idx_q   <= '0;
      count_q     <= '0;
      hwm_q       <= '0;
      sw_idx_q    <= '0;
      sw_v_q      <= 1'b0;
      pass_q      <= 1'b0;
      apply_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_q       <= num_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      hwm_q       <= hwm_d;
      sw_idx_q    <= sw_idx_d;
      sw_v_q      <= sw_v_d;
      pass_q      <= pass_d;
      apply_q     <= apply_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ind_q       <= ind_d;
    gt_q        <= gt_d;
    called_q    <= called_d;
    last_q      <= last_d;
    range_q     <= range_d;
    n_row_q     <= n_row_d;
    k_q         <= k_d;
    m_q         <= m_d;
    prod_q      <= prod_d;
    frac_q      <= frac_d;
    ln_q        <= ln_d;
    inc_q       <= inc_d;
    sw_addr_q   <= sw_addr_d;
    sw_inn_q    <= sw_inn_d;
    out_ind_q   <= out_ind_d;
    out_score_q <= out_score_d;
  end

  `GLSA_ASSERT_NEXT(a_accept_starts_work, in_i.valid && in_i.ready, state_q != ST_IDLE, "accepted item left the block idle")
  `GLSA_ASSERT(a_out_from_read, $rose(out_valid_q) |-> $past(state_q == ST_READ), "score shown without a read")
  `GLSA_ASSERT(a_log_step_bound, (state_q == ST_LOGSQ) |-> (step_q <= STEP_W'(LOG_FRAC)), "log step past last fraction bit")
  `GLSA_ASSERT(a_no_item_in_clear, (state_q == ST_CLEAR) |-> !in_i.ready, "item taken during score clear")

endmodule
